/* sv/memory_type_range_resolver_macros.svh */
// assertion helpers for the range resolver checker
`ifndef MEMORY_TYPE_RANGE_RESOLVER_MACROS_SVH
`define MEMORY_TYPE_RANGE_RESOLVER_MACROS_SVH

`define MTRR_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MTRR_ASSERT_STABLE(label, clk, rst_n, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

/* sv/mtrr_pkg.sv */
package mtrr_pkg;
  localparam int VAR_RANGES_DEF = 16;
  localparam int ADDR_BITS_DEF = 52;
  localparam int FIXED_WORDS = 11;
  localparam int SIZE_BITS = 53;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_LOAD = 2'd3;

  localparam logic [1:0] CFG_VAR_COUNT = 2'd0;
  localparam logic [1:0] CFG_FIXED_EN = 2'd1;
  localparam logic [1:0] CFG_DEF_TYPE = 2'd2;
  localparam logic [1:0] CFG_PRESENT = 2'd3;

  localparam logic [1:0] SRC_VAR = 2'd0;
  localparam logic [1:0] SRC_FIXED = 2'd1;
  localparam logic [1:0] SRC_DEFAULT = 2'd2;

  typedef struct packed {
    logic load;
    logic finish;
  } mtrr_cmd_t;

  function automatic logic [2:0] page_bits_of(input logic [7:0] t);
    logic [2:0] r;
    case (t)
      8'd0: r = 3'd3;
      8'd1: r = 3'd5;
      8'd4: r = 3'd1;
      8'd5: r = 3'd6;
      8'd6: r = 3'd0;
      8'd7: r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction
endpackage

/* sv/mtrr_req_if.sv */
interface mtrr_req_if #(parameter int ADDR_BITS = mtrr_pkg::ADDR_BITS_DEF);
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [3:0] entry_index;
  logic [ADDR_BITS-1:0] range_base;
  logic [mtrr_pkg::SIZE_BITS-1:0] range_size;
  logic [7:0] range_type;
  logic [ADDR_BITS-1:0] lookup_address;
  logic [3:0] fixed_word_index;
  logic [63:0] fixed_word;
  modport source(output valid, op, entry_index, range_base, range_size, range_type,
    lookup_address, fixed_word_index, fixed_word, input ready);
  modport sink(input valid, op, entry_index, range_base, range_size, range_type,
    lookup_address, fixed_word_index, fixed_word, output ready);
endinterface

interface mtrr_rsp_if;
  logic valid;
  logic ready;
  logic ok;
  logic [7:0] mem_type;
  logic [2:0] page_bits;
  logic [1:0] match_source;
  modport source(output valid, ok, mem_type, page_bits, match_source, input ready);
  modport sink(input valid, ok, mem_type, page_bits, match_source, output ready);
endinterface

/* sv/mtrr_ctrl.sv */
module mtrr_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output mtrr_pkg::mtrr_cmd_t cmd
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cmd.load = in_valid && in_ready;
  assign cmd.finish = (state_r == ST_WORK);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_WORK;
      ST_WORK: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* sv/mtrr_dp.sv */
module mtrr_dp #(
  parameter int VAR_RANGES = mtrr_pkg::VAR_RANGES_DEF,
  parameter int ADDR_BITS = mtrr_pkg::ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  mtrr_pkg::mtrr_cmd_t cmd,
  input  logic [1:0] op,
  input  logic [3:0] entry_index,
  input  logic [ADDR_BITS-1:0] range_base,
  input  logic [mtrr_pkg::SIZE_BITS-1:0] range_size,
  input  logic [7:0] range_type,
  input  logic [ADDR_BITS-1:0] lookup_address,
  input  logic [3:0] fixed_word_index,
  input  logic [63:0] fixed_word,
  input  logic [4:0] variable_count,
  input  logic fixed_enabled,
  input  logic [7:0] default_type,
  input  logic ranges_present,
  output logic ok,
  output logic [7:0] mem_type,
  output logic [2:0] page_bits,
  output logic [1:0] match_source
);
  localparam int SW = mtrr_pkg::SIZE_BITS;
  localparam int EW = (ADDR_BITS > SW ? ADDR_BITS : SW) + 1;
  localparam int NF = mtrr_pkg::FIXED_WORDS;

  logic [ADDR_BITS-1:0] vbase_r [VAR_RANGES];
  logic [SW-1:0] vsize_r [VAR_RANGES];
  logic [7:0] vtype_r [VAR_RANGES];
  logic [VAR_RANGES-1:0] vvalid_r;
  logic [63:0] ftypes_r [NF];
  logic [NF-1:0] floaded_r;

  logic [1:0] op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [VAR_RANGES-1:0] hit_r;
  logic set_ok_r;
  logic ok_r;
  logic [7:0] mt_r;
  logic [2:0] pb_r;
  logic [1:0] src_r;

  logic [4:0] active;
  logic set_ok;
  logic [VAR_RANGES-1:0] hit;

  assign active = (variable_count < 5'(VAR_RANGES)) ? variable_count : 5'(VAR_RANGES);
  assign set_ok = ranges_present && ({1'b0, entry_index} < active);

  // range compares on the incoming request, registered into hit_r when it is taken
  always_comb begin
    for (int i = 0; i < VAR_RANGES; i++) begin
      hit[i] = vvalid_r[i] && (5'(i) < active) && (lookup_address >= vbase_r[i]) &&
        (EW'(lookup_address) < EW'(vbase_r[i]) + EW'(vsize_r[i]));
    end
  end

  // priority select and fixed decode on the registered hits, in the work state
  logic var_found;
  logic [7:0] var_t;
  logic [3:0] fw;
  logic [2:0] fb;
  logic fix_hit;
  logic [7:0] fix_t;
  logic [19:0] a20;
  logic [7:0] res_t;
  logic [1:0] res_src;

  always_comb begin
    var_found = 1'b0;
    var_t = 8'd0;
    for (int i = VAR_RANGES - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        var_found = 1'b1;
        var_t = vtype_r[i];
      end
    end
    a20 = addr_r[19:0];
    if (a20 < 20'h80000) begin
      fw = 4'd0;
      fb = a20[18:16];
    end else if (a20 < 20'hC0000) begin
      fw = 4'd1 + {3'd0, a20[17]};
      fb = a20[16:14];
    end else begin
      fw = 4'd3 + {1'b0, a20[17:15]};
      fb = a20[14:12];
    end
    fix_hit = fixed_enabled && (addr_r < ADDR_BITS'(20'hFFFFF) + ADDR_BITS'(1)) &&
      floaded_r[fw];
    fix_t = ftypes_r[fw][{fb, 3'b000} +: 8];
    if (var_found) begin
      res_t = var_t;
      res_src = mtrr_pkg::SRC_VAR;
    end else if (fix_hit) begin
      res_t = fix_t;
      res_src = mtrr_pkg::SRC_FIXED;
    end else begin
      res_t = default_type;
      res_src = mtrr_pkg::SRC_DEFAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      addr_r <= lookup_address;
      hit_r <= hit;
      set_ok_r <= set_ok;
    end
    if (cmd.finish) begin
      if (op_r == mtrr_pkg::OP_LOOKUP) begin
        ok_r <= 1'b1;
        mt_r <= res_t;
        pb_r <= mtrr_pkg::page_bits_of(res_t);
        src_r <= res_src;
      end else begin
        ok_r <= (op_r == mtrr_pkg::OP_LOAD) ? 1'b1 : set_ok_r;
        mt_r <= 8'd0;
        pb_r <= 3'd0;
        src_r <= mtrr_pkg::SRC_VAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VAR_RANGES; i++) begin
      if (cmd.load && op == mtrr_pkg::OP_SET && set_ok && 4'(i) == entry_index) begin
        vbase_r[i] <= range_base;
        vsize_r[i] <= range_size;
        vtype_r[i] <= range_type;
      end
    end
    if (cmd.load && op == mtrr_pkg::OP_LOAD && fixed_word_index < 4'(NF)) begin
      ftypes_r[fixed_word_index] <= fixed_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vvalid_r <= '0;
      floaded_r <= '0;
    end else if (cmd.load) begin
      for (int i = 0; i < VAR_RANGES; i++) begin
        if (set_ok && 4'(i) == entry_index) begin
          if (op == mtrr_pkg::OP_SET) vvalid_r[i] <= 1'b1;
          if (op == mtrr_pkg::OP_CLEAR) vvalid_r[i] <= 1'b0;
        end
      end
      for (int j = 0; j < NF; j++) begin
        if (op == mtrr_pkg::OP_LOAD && 4'(j) == fixed_word_index) floaded_r[j] <= 1'b1;
      end
    end
  end

  assign ok = ok_r;
  assign mem_type = mt_r;
  assign page_bits = pb_r;
  assign match_source = src_r;
endmodule

/* sv/memory_type_range_resolver.sv */
// results register in the work state after a request is taken and are held until taken
// a new request is taken only when idle, once the previous result has been taken
// parallel range compares when a request is taken, then priority select and fixed decode
// reset: range valid and fixed loaded flags clear, configuration registers read zero
module memory_type_range_resolver #(
  parameter int VAR_RANGES = mtrr_pkg::VAR_RANGES_DEF,
  parameter int ADDR_BITS = mtrr_pkg::ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mtrr_req_if.sink in_req,
  mtrr_rsp_if.source out_rsp,
  input  logic cfg_we,
  input  logic [mtrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtrr_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic [4:0] var_count_r;
  logic fixed_en_r;
  logic [7:0] def_type_r;
  logic present_r;
  mtrr_pkg::mtrr_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r <= '0;
      fixed_en_r <= 1'b0;
      def_type_r <= '0;
      present_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mtrr_pkg::CFG_VAR_COUNT: var_count_r <= cfg_data[4:0];
        mtrr_pkg::CFG_FIXED_EN: fixed_en_r <= cfg_data[0];
        mtrr_pkg::CFG_DEF_TYPE: def_type_r <= cfg_data;
        mtrr_pkg::CFG_PRESENT: present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mtrr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_req.valid), .in_ready(in_req.ready),
    .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .cmd(cmd)
  );

  mtrr_dp #(.VAR_RANGES(VAR_RANGES), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .op(in_req.op),
    .entry_index(in_req.entry_index), .range_base(in_req.range_base),
    .range_size(in_req.range_size), .range_type(in_req.range_type),
    .lookup_address(in_req.lookup_address), .fixed_word_index(in_req.fixed_word_index),
    .fixed_word(in_req.fixed_word), .variable_count(var_count_r),
    .fixed_enabled(fixed_en_r), .default_type(def_type_r), .ranges_present(present_r),
    .ok(out_rsp.ok), .mem_type(out_rsp.mem_type), .page_bits(out_rsp.page_bits),
    .match_source(out_rsp.match_source)
  );
endmodule

/* sv/mtrr_checker.sv */
`include "memory_type_range_resolver_macros.svh"
module mtrr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic ok,
  input logic [7:0] mem_type,
  input logic [1:0] match_source
);
  `MTRR_ASSERT_STABLE(a_out_hold, clk, rst_n, out_valid, out_ready, mem_type, "result changed while stalled")
  `MTRR_ASSERT_IMPL(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "request taken while result pending")
  `MTRR_ASSERT_IMPL(a_src_range, clk, rst_n, out_valid |-> (match_source != 2'd3), "bad match source")
  `MTRR_ASSERT_IMPL(a_fail_zero, clk, rst_n, (out_valid && !ok) |-> (mem_type == 8'd0), "refused request has a type")
endmodule

bind memory_type_range_resolver mtrr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .ok(out_rsp.ok),
  .mem_type(out_rsp.mem_type), .match_source(out_rsp.match_source)
);

/* dv/memory_type_range_resolver_tb.sv */
`timescale 1ns / 1ps

module memory_type_range_resolver_tb;
  localparam int NVAR = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  entry_index;
    logic [51:0] range_base;
    logic [52:0] range_size;
    logic [7:0]  range_type;
    logic [51:0] lookup_address;
    logic [3:0]  fixed_word_index;
    logic [63:0] fixed_word;
  } request_t;

  typedef struct {
    logic       ok;
    logic [7:0] mem_type;
    logic [2:0] page_bits;
    logic [1:0] match_source;
  } resolution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mtrr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mtrr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  mtrr_req_if req_if ();
  mtrr_rsp_if rsp_if ();

  memory_type_range_resolver uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(req_if.sink),
    .out_rsp(rsp_if.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block state
  logic [51:0] sh_base [NVAR];
  logic [52:0] sh_size [NVAR];
  logic [7:0]  sh_type [NVAR];
  logic        sh_valid [NVAR];
  logic [63:0] sh_fixed [mtrr_pkg::FIXED_WORDS];
  logic        sh_loaded [mtrr_pkg::FIXED_WORDS];
  logic [4:0]  sh_count = '0;
  logic        sh_fixed_en = 1'b0;
  logic [7:0]  sh_default = '0;
  logic        sh_present = 1'b0;

  resolution_t pending_results [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cnt = 0;
  bit hold_trigger = 1'b0;
  int quiet_cycles = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.op = mtrr_pkg::OP_LOOKUP;
    req_if.entry_index = '0;
    req_if.range_base = '0;
    req_if.range_size = '0;
    req_if.range_type = '0;
    req_if.lookup_address = '0;
    req_if.fixed_word_index = '0;
    req_if.fixed_word = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < NVAR; i++) begin
      sh_base[i] = '0; sh_size[i] = '0; sh_type[i] = '0; sh_valid[i] = 1'b0;
    end
    for (int i = 0; i < mtrr_pkg::FIXED_WORDS; i++) begin
      sh_fixed[i] = '0; sh_loaded[i] = 1'b0;
    end
  end

  function automatic logic [2:0] attr_bits(logic [7:0] t);
    case (t)
      8'd0: return 3'd3;
      8'd1: return 3'd5;
      8'd4: return 3'd1;
      8'd5: return 3'd6;
      8'd7: return 3'd2;
      default: return 3'd0;
    endcase
  endfunction

  function automatic resolution_t resolve_request(request_t r);
    resolution_t res;
    int n;
    int w;
    int b;
    bit found;
    logic [19:0] a;
    logic [53:0] lim;
    res = '{1'b1, 8'd0, 3'd0, mtrr_pkg::SRC_VAR};
    n = (int'(sh_count) < NVAR) ? int'(sh_count) : NVAR;
    found = 1'b0;
    if (r.op == mtrr_pkg::OP_LOOKUP) begin
      for (int i = 0; i < n; i++) begin
        lim = {2'b00, sh_base[i]} + {1'b0, sh_size[i]};
        if (!found && sh_valid[i] && r.lookup_address >= sh_base[i] &&
            {2'b00, r.lookup_address} < lim) begin
          res.mem_type = sh_type[i];
          res.match_source = mtrr_pkg::SRC_VAR;
          found = 1'b1;
        end
      end
      if (!found && sh_fixed_en && r.lookup_address < 52'h100000) begin
        a = r.lookup_address[19:0];
        if (a < 20'h80000) begin
          w = 0; b = int'(a >> 16);
        end else if (a < 20'hC0000) begin
          w = 1 + int'((a - 20'h80000) >> 17); b = int'(((a - 20'h80000) >> 14) & 20'd7);
        end else begin
          w = 3 + int'((a - 20'hC0000) >> 15); b = int'(((a - 20'hC0000) >> 12) & 20'd7);
        end
        if (w < mtrr_pkg::FIXED_WORDS && sh_loaded[w]) begin
          res.mem_type = sh_fixed[w][b*8 +: 8];
          res.match_source = mtrr_pkg::SRC_FIXED;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.mem_type = sh_default;
        res.match_source = mtrr_pkg::SRC_DEFAULT;
      end
      res.page_bits = attr_bits(res.mem_type);
    end else if (r.op == mtrr_pkg::OP_SET || r.op == mtrr_pkg::OP_CLEAR) begin
      if (!sh_present || r.entry_index >= n) begin
        res.ok = 1'b0;
      end else if (r.op == mtrr_pkg::OP_SET) begin
        sh_base[r.entry_index] = r.range_base;
        sh_size[r.entry_index] = r.range_size;
        sh_type[r.entry_index] = r.range_type;
        sh_valid[r.entry_index] = 1'b1;
      end else begin
        sh_valid[r.entry_index] = 1'b0;
      end
    end else if (r.fixed_word_index < mtrr_pkg::FIXED_WORDS) begin
      sh_fixed[r.fixed_word_index] = r.fixed_word;
      sh_loaded[r.fixed_word_index] = 1'b1;
    end
    return res;
  endfunction

  task automatic send_request(request_t r);
    req_if.op <= r.op;
    req_if.entry_index <= r.entry_index;
    req_if.range_base <= r.range_base;
    req_if.range_size <= r.range_size;
    req_if.range_type <= r.range_type;
    req_if.lookup_address <= r.lookup_address;
    req_if.fixed_word_index <= r.fixed_word_index;
    req_if.fixed_word <= r.fixed_word;
    req_if.valid <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(resolve_request(r));
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mtrr_pkg::CFG_VAR_COUNT: sh_count = data[4:0];
      mtrr_pkg::CFG_FIXED_EN: sh_fixed_en = data[0];
      mtrr_pkg::CFG_DEF_TYPE: sh_default = data;
      mtrr_pkg::CFG_PRESENT: sh_present = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] cnt, logic [7:0] fen, logic [7:0] dt, logic [7:0] pr);
    write_cfg(mtrr_pkg::CFG_VAR_COUNT, cnt);
    write_cfg(mtrr_pkg::CFG_FIXED_EN, fen);
    write_cfg(mtrr_pkg::CFG_DEF_TYPE, dt);
    write_cfg(mtrr_pkg::CFG_PRESENT, pr);
  endtask

  function automatic request_t mk(logic [1:0] op, logic [3:0] idx, logic [51:0] base,
                                  logic [52:0] size, logic [7:0] t, logic [51:0] addr,
                                  logic [3:0] widx, logic [63:0] word);
    request_t r;
    r = '{op, idx, base, size, t, addr, widx, word};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t random_request();
    request_t r;
    int k;
    int sel;
    r = mk(mtrr_pkg::OP_LOOKUP, 4'($urandom_range(15)), 52'(rand64()), 53'(rand64()),
           8'($urandom_range(255)), 52'(rand64()), 4'($urandom_range(15)), rand64());
    sel = $urandom_range(99);
    if (sel < 50) r.op = mtrr_pkg::OP_LOOKUP;
    else if (sel < 70) r.op = mtrr_pkg::OP_SET;
    else if (sel < 80) r.op = mtrr_pkg::OP_CLEAR;
    else r.op = mtrr_pkg::OP_LOAD;
    if ($urandom_range(3) != 0) r.entry_index = 4'($urandom_range(9));
    case ($urandom_range(3))
      0: r.range_base = 52'($urandom_range(20'hFFFFF));
      1: r.range_base = 52'({$urandom_range(3), $urandom} << $urandom_range(20));
      2: r.range_base = '1;
      default: ;
    endcase
    case ($urandom_range(4))
      0: r.range_size = 53'($urandom_range(20'h3FFFF));
      1: r.range_size = 53'd0;
      2: r.range_size = 53'h10000000000000;
      3: r.range_size = 53'($urandom);
      default: ;
    endcase
    if ($urandom_range(3) == 0) r.range_type = 8'($urandom_range(7));
    if ($urandom_range(5) != 0) r.fixed_word_index = 4'($urandom_range(10));
    k = $urandom_range(NVAR - 1);
    case ($urandom_range(5))
      0: r.lookup_address = 52'(sh_base[k] + 52'($urandom_range(255)));
      1: r.lookup_address = 52'(sh_base[k] + sh_size[k][51:0] - 52'($urandom_range(1)));
      2: r.lookup_address = 52'(sh_base[k] - 52'd1);
      3, 4: r.lookup_address = 52'($urandom_range(20'hFFFFF));
      default: ;
    endcase
    return r;
  endfunction

  // response checker
  always @(posedge clk) begin
    resolution_t e;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result ok=%0d type=%0d bits=%0d src=%0d", $time,
                 rsp_if.ok, rsp_if.mem_type, rsp_if.page_bits, rsp_if.match_source);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (rsp_if.ok !== e.ok || rsp_if.mem_type !== e.mem_type ||
            rsp_if.page_bits !== e.page_bits || rsp_if.match_source !== e.match_source) begin
          $display({"%0t mismatch expected ok=%0d type=%0d bits=%0d src=%0d",
                    " actual ok=%0d type=%0d bits=%0d src=%0d"},
                   $time, e.ok, e.mem_type, e.page_bits, e.match_source, rsp_if.ok,
                   rsp_if.mem_type, rsp_if.page_bits, rsp_if.match_source);
          errors++;
        end
      end
    end
  end

  // receiver ready with optional long hold-off
  always @(posedge clk) begin
    if (hold_trigger) begin
      hold_cnt = 300;
      hold_trigger = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_reset_state();
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'h0, '0, '0));
    send_request(mk(mtrr_pkg::OP_SET, '0, 52'h1000, 53'h1000, 8'd6, '0, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'h1000, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOAD, '0, '0, '0, '0, '0, 4'd0, 64'h0706050401000706));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'h10000, '0, '0));
  endtask

  task automatic test_directed();
    configure(8'hFF, 8'h01, 8'd6, 8'h01);
    send_request(mk(mtrr_pkg::OP_SET, 4'd15, '1, 53'h10000000000000, 8'hFF, '0, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, '1, '0, '0));
    send_request(mk(mtrr_pkg::OP_SET, 4'd0, 52'h2000, 53'd0, 8'd1, '0, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'h2000, '0, '0));
    send_request(mk(mtrr_pkg::OP_SET, 4'd1, 52'h0, 53'h80001, 8'd4, '0, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'h80000, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'h80001, '0, '0));
    send_request(mk(mtrr_pkg::OP_CLEAR, 4'd1, '0, '0, '0, '0, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOAD, '0, '0, '0, '0, '0, 4'd2, 64'hFFEE070605040100));
    send_request(mk(mtrr_pkg::OP_LOAD, '0, '0, '0, '0, '0, 4'd10, 64'h0102030405060708));
    send_request(mk(mtrr_pkg::OP_LOAD, '0, '0, '0, '0, '0, 4'd11, '1));
    send_request(mk(mtrr_pkg::OP_LOAD, '0, '0, '0, '0, '0, 4'd15, '1));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'hBFFFF, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'hFFFFF, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'hC0000, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, 52'h100000, '0, '0));
    write_cfg(mtrr_pkg::CFG_VAR_COUNT, 8'd5);
    send_request(mk(mtrr_pkg::OP_SET, 4'd7, 52'h0, 53'h100, 8'd5, '0, '0, '0));
    send_request(mk(mtrr_pkg::OP_CLEAR, 4'd4, '0, '0, '0, '0, '0, '0));
    send_request(mk(mtrr_pkg::OP_LOOKUP, '0, '0, '0, '0, '1, '0, '0));
  endtask

  task automatic test_random_phase(int items, int s_idle, int r_stall);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    for (int i = 0; i < items; i++) send_request(random_request());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_trigger = 1'b1;
    for (int i = 0; i < 30; i++) send_request(random_request());
    drain();
    for (int i = 0; i < 20; i++) send_request(random_request());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    configure(8'd16, 8'h01, 8'd0, 8'h01);
    test_random_phase(350, 0, 0);
    configure(8'd8, 8'h00, 8'hFF, 8'h01);
    test_random_phase(300, 83, 0);
    configure(8'h1F, 8'h01, 8'd7, 8'h01);
    test_random_phase(300, 0, 83);
    configure(8'd0, 8'h01, 8'd1, 8'h00);
    test_random_phase(150, 25, 25);
    configure(8'd12, 8'h01, 8'd4, 8'h01);
    test_random_phase(250, 25, 25);
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
